FILE: src/cmtw_pkg.sv
// Shared types and constants for the color markup text writer.
`default_nettype none

package cmtw_pkg;

    // Parameter defaults
    localparam int DEF_MAX_COLS = 256;
    localparam int DEF_MAX_ROWS = 256;

    // Field widths
    localparam int CHAR_W   = 21;
    localparam int POS_W    = 16;
    localparam int DIM_W    = 9;
    localparam int COLOR_W  = 32;
    localparam int COUNT_W  = 16;
    localparam int REG_IDX_W = 2;

    // Colors and character codes
    localparam logic [COLOR_W-1:0] COLOR_WHITE        = 32'hFFFF_FFFF;
    localparam logic [COLOR_W-1:0] COLOR_OPAQUE_BLACK = 32'h0000_00FF;
    localparam logic [7:0]         ALPHA_OPAQUE       = 8'hFF;

    localparam logic [CHAR_W-1:0] CH_LBRACK = 21'h5B;
    localparam logic [CHAR_W-1:0] CH_RBRACK = 21'h5D;
    localparam logic [CHAR_W-1:0] CH_FG     = 21'h66;
    localparam logic [CHAR_W-1:0] CH_BG     = 21'h62;
    localparam logic [CHAR_W-1:0] CH_DEF    = 21'h64;
    localparam logic [CHAR_W-1:0] CH_COMMA  = 21'h2C;
    localparam logic [CHAR_W-1:0] CH_ZERO   = 21'h30;
    localparam logic [CHAR_W-1:0] CH_NINE   = 21'h39;

    // Configuration reset values
    localparam logic [DIM_W-1:0]   RST_SCREEN_WIDTH  = 9'd80;
    localparam logic [DIM_W-1:0]   RST_SCREEN_HEIGHT = 9'd25;
    localparam logic [COLOR_W-1:0] RST_DEFAULT_FG    = 32'hFFFF_FFFF;
    localparam logic [COLOR_W-1:0] RST_DEFAULT_BG    = 32'h0000_00FF;

    // Result kinds
    localparam logic KIND_GLYPH   = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_SCREEN_WIDTH  = 2'd0,
        REG_SCREEN_HEIGHT = 2'd1,
        REG_DEFAULT_FG    = 2'd2,
        REG_DEFAULT_BG    = 2'd3
    } reg_idx_t;

    typedef enum logic [5:0] {
        MODE_TEXT   = 6'b000001,
        MODE_OPEN   = 6'b000010,
        MODE_SCAN   = 6'b000100,
        MODE_SEL    = 6'b001000,
        MODE_DAFTER = 6'b010000,
        MODE_FIELDS = 6'b100000
    } mode_t;

    typedef struct packed {
        logic [CHAR_W-1:0]       char_code;
        logic signed [POS_W-1:0] start_col;
        logic signed [POS_W-1:0] start_row;
        logic                    first_of_string;
        logic                    last_of_string;
    } item_t;

    typedef struct packed {
        logic [DIM_W-1:0]   screen_width;
        logic [DIM_W-1:0]   screen_height;
        logic [COLOR_W-1:0] default_fg;
        logic [COLOR_W-1:0] default_bg;
    } cfg_t;

    typedef struct packed {
        logic               kind;
        logic [7:0]         col;
        logic [7:0]         row;
        logic [CHAR_W-1:0]  glyph_code;
        logic [COLOR_W-1:0] fg_color;
        logic [COLOR_W-1:0] bg_color;
        logic [COUNT_W-1:0] glyph_count;
        logic               last_of_run;
    } res_t;

endpackage

`default_nettype wire

FILE: src/cmtw_in_if.sv
// Character input channel: valid/ready with the character payload.
`default_nettype none

interface cmtw_in_if;
    logic               valid;
    logic               ready;
    logic [20:0]        char_code;
    logic signed [15:0] start_col;
    logic signed [15:0] start_row;
    logic               first_of_string;
    logic               last_of_string;

    modport source (
        output valid, char_code, start_col, start_row, first_of_string, last_of_string,
        input  ready
    );
    modport sink (
        input  valid, char_code, start_col, start_row, first_of_string, last_of_string,
        output ready
    );
endinterface

`default_nettype wire

FILE: src/cmtw_out_if.sv
// Result output channel: valid/ready with glyph write or summary payload.
`default_nettype none

interface cmtw_out_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  col;
    logic [7:0]  row;
    logic [20:0] glyph_code;
    logic [31:0] fg_color;
    logic [31:0] bg_color;
    logic [15:0] glyph_count;
    logic        last_of_run;

    modport source (
        output valid, kind, col, row, glyph_code, fg_color, bg_color, glyph_count,
               last_of_run,
        input  ready
    );
    modport sink (
        input  valid, kind, col, row, glyph_code, fg_color, bg_color, glyph_count,
               last_of_run,
        output ready
    );
endinterface

`default_nettype wire

FILE: src/cmtw_parse.sv
// Markup parser and string state: one character per fire, up to two results.
`default_nettype none

module cmtw_parse
    import cmtw_pkg::*;
#(
    parameter int MAX_COLS = DEF_MAX_COLS,
    parameter int MAX_ROWS = DEF_MAX_ROWS
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       fire,
    input  item_t      item,
    input  cfg_t       cfg,
    output logic [1:0] res_n,
    output res_t       res0,
    output res_t       res1
);

    localparam int CMP_W = 17;
    localparam logic [CMP_W-1:0] MAX_COLS_V = CMP_W'(MAX_COLS);
    localparam logic [CMP_W-1:0] MAX_ROWS_V = CMP_W'(MAX_ROWS);
    localparam logic [COUNT_W-1:0] COUNT_SAT = '1;
    localparam logic signed [CMP_W-1:0] COL_SAT = 17'sd65535;

    // State registers
    mode_t                      mode_reg, mode_next;
    logic [COLOR_W-1:0]         fg_reg, fg_next;
    logic [COLOR_W-1:0]         bg_reg, bg_next;
    logic [23:0]                prgb_reg, prgb_next;
    logic [7:0]                 fval_reg, fval_next;
    logic                       fempty_reg, fempty_next;
    logic [1:0]                 fidx_reg, fidx_next;
    logic                       tbg_reg, tbg_next;
    logic signed [CMP_W-1:0]    ncol_reg, ncol_next;
    logic signed [POS_W-1:0]    row_reg, row_next;
    logic signed [POS_W-1:0]    sx_reg, sx_next;
    logic                       rej_reg, rej_next;
    logic [COUNT_W-1:0]         count_reg, count_next;
    logic [COUNT_W-1:0]         slen_reg, slen_next;

    logic [CMP_W-1:0]   eff_w, eff_h;
    logic               glyph_en, glyph_vis, do_field;
    logic [CHAR_W-1:0]  glyph_c;
    logic [7:0]         fval_use;
    logic [CMP_W:0]     end_col;
    logic               zero_count;
    res_t               glyph_res, sum_res;

    // Clip the configured screen to the supported size
    assign eff_w = (CMP_W'(cfg.screen_width) < MAX_COLS_V) ? CMP_W'(cfg.screen_width)
                                                           : MAX_COLS_V;
    assign eff_h = (CMP_W'(cfg.screen_height) < MAX_ROWS_V) ? CMP_W'(cfg.screen_height)
                                                            : MAX_ROWS_V;

    // Next state and results for one character
    always_comb
    begin
        mode_next   = mode_reg;
        fg_next     = fg_reg;
        bg_next     = bg_reg;
        prgb_next   = prgb_reg;
        fval_next   = fval_reg;
        fempty_next = fempty_reg;
        fidx_next   = fidx_reg;
        tbg_next    = tbg_reg;
        ncol_next   = ncol_reg;
        row_next    = row_reg;
        sx_next     = sx_reg;
        rej_next    = rej_reg;
        count_next  = count_reg;
        slen_next   = slen_reg;
        glyph_en    = 1'b0;
        glyph_vis   = 1'b0;
        glyph_c     = item.char_code;
        do_field    = 1'b0;
        fval_use    = 8'd0;
        glyph_res   = '0;
        sum_res     = '0;
        end_col     = '0;
        zero_count  = 1'b0;

        // New string: fresh colors and parser, sample position
        if (item.first_of_string)
        begin
            mode_next   = MODE_TEXT;
            fg_next     = COLOR_WHITE;
            bg_next     = COLOR_OPAQUE_BLACK;
            prgb_next   = '0;
            fval_next   = '0;
            fempty_next = 1'b1;
            fidx_next   = '0;
            tbg_next    = 1'b0;
            count_next  = '0;
            slen_next   = '0;
            sx_next     = item.start_col;
            row_next    = item.start_row;
            ncol_next   = CMP_W'(item.start_col);
            rej_next    = item.start_row[POS_W-1] ||
                          ({1'b0, item.start_row} >= eff_h) ||
                          (!item.start_col[POS_W-1] && ({1'b0, item.start_col} >= eff_w));
        end

        if (slen_next != COUNT_SAT)
        begin
            slen_next = slen_next + 1'b1;
        end

        // Parser step
        case (mode_next)
            MODE_TEXT:
            begin
                if (item.char_code == CH_LBRACK)
                begin
                    mode_next = MODE_OPEN;
                end
                else
                begin
                    glyph_en = 1'b1;
                end
            end
            MODE_OPEN, MODE_SCAN:
            begin
                if (mode_next == MODE_OPEN && item.char_code == CH_LBRACK)
                begin
                    glyph_en  = 1'b1;
                    glyph_c   = CH_LBRACK;
                    mode_next = MODE_TEXT;
                end
                else if (item.char_code == CH_FG || item.char_code == CH_BG)
                begin
                    tbg_next  = (item.char_code == CH_BG);
                    mode_next = MODE_SEL;
                end
                else
                begin
                    mode_next = MODE_SCAN;
                end
            end
            MODE_SEL:
            begin
                if (item.char_code == CH_DEF)
                begin
                    if (tbg_next)
                    begin
                        bg_next = cfg.default_bg;
                    end
                    else
                    begin
                        fg_next = cfg.default_fg;
                    end
                    mode_next = MODE_DAFTER;
                end
                else
                begin
                    do_field = 1'b1;
                end
            end
            MODE_DAFTER:
            begin
                if (item.char_code == CH_RBRACK)
                begin
                    mode_next = MODE_TEXT;
                end
                else
                begin
                    do_field = 1'b1;
                end
            end
            MODE_FIELDS:
            begin
                do_field = 1'b1;
            end
            default:
            begin
                mode_next = MODE_TEXT;
            end
        endcase

        // Open the field list when entering it from a selector
        if (do_field && mode_next != MODE_FIELDS)
        begin
            prgb_next   = '0;
            fval_next   = '0;
            fempty_next = 1'b1;
            fidx_next   = '0;
            mode_next   = MODE_FIELDS;
        end

        // Decimal color fields
        if (do_field)
        begin
            if (item.char_code inside {[CH_ZERO:CH_NINE]})
            begin
                fval_next   = (fval_next << 3) + (fval_next << 1) +
                              8'(item.char_code - CH_ZERO);
                fempty_next = 1'b0;
            end
            else if (item.char_code == CH_COMMA && fidx_next != 2'd3)
            begin
                fval_use = fempty_next ? 8'd0 : fval_next;
                case (fidx_next)
                    2'd0:    prgb_next[23:16] = prgb_next[23:16] | fval_use;
                    2'd1:    prgb_next[15:8]  = prgb_next[15:8]  | fval_use;
                    default: prgb_next[7:0]   = prgb_next[7:0]   | fval_use;
                endcase
                fidx_next   = fidx_next + 1'b1;
                fval_next   = '0;
                fempty_next = 1'b1;
            end
            else if (item.char_code == CH_RBRACK && fidx_next == 2'd3)
            begin
                fval_use = fempty_next ? ALPHA_OPAQUE : fval_next;
                if (tbg_next)
                begin
                    bg_next = {prgb_next, fval_use};
                end
                else
                begin
                    fg_next = {prgb_next, fval_use};
                end
                mode_next = MODE_TEXT;
            end
        end

        // Glyph write, clipped to the screen
        if (glyph_en)
        begin
            if (count_next != COUNT_SAT)
            begin
                count_next = count_next + 1'b1;
            end
            glyph_vis = !rej_next && !ncol_next[CMP_W-1] && (ncol_next < $signed(eff_w)) &&
                        !row_next[POS_W-1] && ({1'b0, row_next} < eff_h);
            glyph_res.kind        = KIND_GLYPH;
            glyph_res.col         = ncol_next[7:0];
            glyph_res.row         = row_next[7:0];
            glyph_res.glyph_code  = glyph_c;
            glyph_res.fg_color    = fg_next;
            glyph_res.bg_color    = bg_next;
            glyph_res.last_of_run = !item.last_of_string;
            if (ncol_next < COL_SAT)
            begin
                ncol_next = ncol_next + 17'sd1;
            end
        end

        // End-of-string summary, then reset the per-string state
        if (item.last_of_string)
        begin
            end_col    = {{2{sx_next[POS_W-1]}}, sx_next} + {2'b00, slen_next};
            zero_count = rej_next || end_col[CMP_W];
            sum_res.kind        = KIND_SUMMARY;
            sum_res.glyph_count = zero_count ? '0 : count_next;
            sum_res.last_of_run = 1'b1;
            mode_next   = MODE_TEXT;
            fg_next     = COLOR_WHITE;
            bg_next     = COLOR_OPAQUE_BLACK;
            prgb_next   = '0;
            fval_next   = '0;
            fempty_next = 1'b1;
            fidx_next   = '0;
            tbg_next    = 1'b0;
            count_next  = '0;
            slen_next   = '0;
        end
    end

    // Order results: glyph first, summary after it
    assign res_n = {1'b0, glyph_vis} + {1'b0, item.last_of_string};
    assign res0  = glyph_vis ? glyph_res : sum_res;
    assign res1  = sum_res;

    // Advance state on each processed character
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_TEXT;
            fg_reg     <= COLOR_WHITE;
            bg_reg     <= COLOR_OPAQUE_BLACK;
            prgb_reg   <= '0;
            fval_reg   <= '0;
            fempty_reg <= 1'b1;
            fidx_reg   <= '0;
            tbg_reg    <= 1'b0;
            ncol_reg   <= '0;
            row_reg    <= '0;
            sx_reg     <= '0;
            rej_reg    <= 1'b0;
            count_reg  <= '0;
            slen_reg   <= '0;
        end
        else if (fire)
        begin
            mode_reg   <= mode_next;
            fg_reg     <= fg_next;
            bg_reg     <= bg_next;
            prgb_reg   <= prgb_next;
            fval_reg   <= fval_next;
            fempty_reg <= fempty_next;
            fidx_reg   <= fidx_next;
            tbg_reg    <= tbg_next;
            ncol_reg   <= ncol_next;
            row_reg    <= row_next;
            sx_reg     <= sx_next;
            rej_reg    <= rej_next;
            count_reg  <= count_next;
            slen_reg   <= slen_next;
        end
    end

`ifndef SYNTH
    // A finished string leaves the parser in text mode with counters cleared
    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        fire && item.last_of_string |=>
            mode_reg == MODE_TEXT && count_reg == '0 && slen_reg == '0)
        else $error("string state not cleared after last character");

    // Hold all string state while no character is processed
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(mode_reg) && $stable(count_reg) && $stable(ncol_reg))
        else $error("string state changed without a character");

    // A string on a negative row is always rejected
    a_neg_row: assert property (@(posedge clk) disable iff (!rst_n)
        fire && item.first_of_string && item.start_row[POS_W-1] |=> rej_reg)
        else $error("negative row not rejected");
`endif

endmodule

`default_nettype wire

FILE: src/color_markup_text_writer_core.sv
// Top level of the color markup text writer: ports, config, input and result buffers.
//
//  channel  | dir | handshake      | payload
//  ---------+-----+----------------+------------------------------------------------
//  text     | in  | valid/ready    | char_code, start_col, start_row, first/last
//  glyphs   | out | valid/ready    | kind, col, row, glyph_code, colors, count, last
//  wr_*     | in  | wr_en          | wr_index, wr_data (write only)
//
// A character is parsed from the input register once the result buffer has room; its
// results land in a two-entry result buffer, which drives the output.
// Sustained rate is one character per cycle while the output is ready; a character
// that yields both a glyph and a summary holds back the next character, since the
// output port drains one result per cycle. The input register holds one character
// while results wait; text.ready stays low until the parser advances. Reset clears
// the parser state and the buffers and restores the configuration defaults.
`default_nettype none

module color_markup_text_writer_core
    import cmtw_pkg::*;
#(
    parameter int MAX_COLS = DEF_MAX_COLS,
    parameter int MAX_ROWS = DEF_MAX_ROWS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    cmtw_in_if.sink              text,
    cmtw_out_if.source           glyphs,
    input  logic                 wr_en,
    input  logic [REG_IDX_W-1:0] wr_index,
    input  logic [COLOR_W-1:0]   wr_data
);

    cfg_t       cfg_reg;
    item_t      item_reg;
    logic       ivalid_reg;
    res_t       res0_reg, res1_reg;
    logic [1:0] cnt_reg;

    logic       pop, adv;
    logic [1:0] res_n;
    res_t       res0, res1;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.screen_width  <= RST_SCREEN_WIDTH;
            cfg_reg.screen_height <= RST_SCREEN_HEIGHT;
            cfg_reg.default_fg    <= RST_DEFAULT_FG;
            cfg_reg.default_bg    <= RST_DEFAULT_BG;
        end
        else if (wr_en)
        begin
            case (reg_idx_t'(wr_index))
                REG_SCREEN_WIDTH:  cfg_reg.screen_width  <= wr_data[DIM_W-1:0];
                REG_SCREEN_HEIGHT: cfg_reg.screen_height <= wr_data[DIM_W-1:0];
                REG_DEFAULT_FG:    cfg_reg.default_fg    <= wr_data;
                REG_DEFAULT_BG:    cfg_reg.default_bg    <= wr_data;
                default:           cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Handshake: pop the head result, advance the input once the buffer frees up
    assign pop        = (cnt_reg != 2'd0) && glyphs.ready;
    assign adv        = ivalid_reg && ((cnt_reg == 2'd0) || (cnt_reg == 2'd1 && pop));
    assign text.ready = !ivalid_reg || adv;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ivalid_reg <= 1'b0;
        end
        else if (text.ready)
        begin
            ivalid_reg <= text.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (text.valid && text.ready)
        begin
            item_reg.char_code       <= text.char_code;
            item_reg.start_col       <= text.start_col;
            item_reg.start_row       <= text.start_row;
            item_reg.first_of_string <= text.first_of_string;
            item_reg.last_of_string  <= text.last_of_string;
        end
    end

    cmtw_parse #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_parse (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (adv),
        .item  (item_reg),
        .cfg   (cfg_reg),
        .res_n (res_n),
        .res0  (res0),
        .res1  (res1)
    );

    // Result buffer occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else if (adv)
        begin
            cnt_reg <= res_n;
        end
        else if (pop)
        begin
            cnt_reg <= cnt_reg - 2'd1;
        end
    end

    // Result buffer payload: load a new pair or shift the second up
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            res0_reg <= res0;
            res1_reg <= res1;
        end
        else if (pop)
        begin
            res0_reg <= res1_reg;
        end
    end

    // Drive the output channel from the head entry
    assign glyphs.valid       = (cnt_reg != 2'd0);
    assign glyphs.kind        = res0_reg.kind;
    assign glyphs.col         = res0_reg.col;
    assign glyphs.row         = res0_reg.row;
    assign glyphs.glyph_code  = res0_reg.glyph_code;
    assign glyphs.fg_color    = res0_reg.fg_color;
    assign glyphs.bg_color    = res0_reg.bg_color;
    assign glyphs.glyph_count = res0_reg.glyph_count;
    assign glyphs.last_of_run = res0_reg.last_of_run;

`ifndef SYNTH
    // The buffer never holds more than two results
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3)
        else $error("result buffer overflow");

    // A summary always closes the run of results for its character
    a_sum_last: assert property (@(posedge clk) disable iff (!rst_n)
        glyphs.valid && glyphs.kind == KIND_SUMMARY |-> glyphs.last_of_run)
        else $error("summary without last_of_run");

    // Two buffered results come from one character: a glyph ahead of its summary
    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == 2'd2 |-> res0_reg.kind == KIND_GLYPH && !res0_reg.last_of_run &&
                            res1_reg.kind == KIND_SUMMARY)
        else $error("bad result pair in buffer");

    // A full input register with a full buffer takes no new character
    a_stall_in: assert property (@(posedge clk) disable iff (!rst_n)
        ivalid_reg && cnt_reg == 2'd2 |-> !text.ready)
        else $error("input accepted while parser blocked");
`endif

endmodule

`default_nettype wire
